// ----- rtl/sdf_pkg.sv -----
package sdf_pkg;

  localparam int unsigned AccessAddrWidth = 48;
  localparam int unsigned AddrBitsDefault = 48;
  localparam int unsigned StateWidth      = 3;

  localparam logic [StateWidth-1:0] StStart   = 3'd0;
  localparam logic [StateWidth-1:0] StFirst   = 3'd1;
  localparam logic [StateWidth-1:0] StLearned = 3'd2;
  localparam logic [StateWidth-1:0] StWeak    = 3'd3;
  localparam logic [StateWidth-1:0] StStrong  = 3'd4;

endpackage

// ----- rtl/stride_detector_fsm_top.sv -----
// stride detector: one memory address per request, one result per request.
// input channel: in_valid_i / in_ready_o with access_address_i.
// output channel: out_valid_o / out_ready_i with is_stride_o and fsm_state_o,
// the machine state after the update and a flag for weak or strong stride.
// only the low ADDR_BITS bits of the address take part in the update.
// an accepted request lands in the input register; once the result register
// is free or its result is being taken, the request is applied to the
// stride state and written to the result register, which offers its result.
// throughput: one request per cycle without a stall; the state update is one
// subtract, one compare and a state change between input and result registers.
// when the receiver stalls, the result register holds its value and the
// input register holds one more request; further requests are refused
// until the result is taken. the input side keeps taking requests while a
// finished result waits, as long as the input register drains.
// reset clears both valid flags, the state to start, and the previous
// address, first address and stride to zero.
module stride_detector_fsm_top import sdf_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [AccessAddrWidth-1:0] access_address_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       is_stride_o,
  output logic [StateWidth-1:0]      fsm_state_o
);

  logic                       in_valid_q;
  logic [AccessAddrWidth-1:0] in_addr_q;
  logic                       out_valid_q;
  logic                       is_stride_q, is_stride_d;
  logic [StateWidth-1:0]      res_state_q;
  logic [StateWidth-1:0]      state_q, state_d;
  logic [ADDR_BITS-1:0]       prev_q, prev_d;
  logic [ADDR_BITS-1:0]       first_q, first_d;
  logic [ADDR_BITS-1:0]       stride_q, stride_d;
  logic [ADDR_BITS-1:0]       addr;
  logic [ADDR_BITS-1:0]       diff;
  logic                       match;
  logic                       advance;

  // low address bits, zero extended when the state is wider than the port
  generate
    if (ADDR_BITS <= AccessAddrWidth) begin : g_trunc
      assign addr = in_addr_q[ADDR_BITS-1:0];
    end else begin : g_ext
      assign addr = {{(ADDR_BITS-AccessAddrWidth){1'b0}}, in_addr_q};
    end
  endgenerate

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign diff  = addr - prev_q;
  assign match = (diff == stride_q);

  always_comb begin
    state_d  = state_q;
    prev_d   = prev_q;
    first_d  = first_q;
    stride_d = stride_q;
    case (state_q)
      StFirst: begin
        stride_d = addr - first_q;
        prev_d   = addr;
        state_d  = StLearned;
      end
      StLearned: begin
        if (match) begin
          if (diff != '0) begin
            prev_d  = addr;
            state_d = StWeak;
          end
        end else begin
          first_d  = addr;
          prev_d   = '0;
          stride_d = '0;
          state_d  = StFirst;
        end
      end
      StWeak: begin
        if (match) begin
          prev_d  = addr;
          state_d = StStrong;
        end else begin
          state_d = StLearned;
        end
      end
      StStrong: begin
        if (match) begin
          prev_d = addr;
        end else begin
          state_d = StWeak;
        end
      end
      default: begin
        first_d = addr;
        state_d = StFirst;
      end
    endcase
    is_stride_d = (state_d == StWeak) || (state_d == StStrong);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StStart;
      prev_q      <= '0;
      first_q     <= '0;
      stride_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        prev_q      <= prev_d;
        first_q     <= first_d;
        stride_q    <= stride_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_addr_q <= access_address_i;
    end
    if (advance) begin
      is_stride_q <= is_stride_d;
      res_state_q <= state_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_stride_o = is_stride_q;
  assign fsm_state_o = res_state_q;

endmodule

// ----- rtl/sdf_checker.sv -----
module sdf_checker import sdf_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       is_stride_o,
  input logic [StateWidth-1:0]      fsm_state_o
);

  logic [StateWidth-1:0] last_state_q;

  // state of the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_state_q <= StStart;
    end else if (out_valid_o && out_ready_i) begin
      last_state_q <= fsm_state_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fsm_state_o)
      && $stable(is_stride_o))
    else $error("result changed while stalled");

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_stride_o == ((fsm_state_o == StWeak) || (fsm_state_o == StStrong)))
    else $error("stride flag disagrees with state");

  a_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fsm_state_o == StFirst) || (fsm_state_o == StLearned)
      || (fsm_state_o == StWeak) || (fsm_state_o == StStrong))
    else $error("result state is start or unused");

  a_strong_pred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fsm_state_o == StStrong)
      |-> (last_state_q == StWeak) || (last_state_q == StStrong))
    else $error("strong stride without prior stride state");

endmodule

bind stride_detector_fsm_top sdf_checker u_sdf_checker (.*);
